>>> src/tbvf_pkg.sv
// Shared definitions for the three-body vector field unit.
// Default sizes, queue depths and the pipeline control bundle.
// Depends on nothing; imported by the square root, divider, back part, top level and testbench.
`default_nettype none

package tbvf_pkg;

    localparam int DEF_WORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 28;
    localparam int CFG_WIDTH      = 32;
    localparam int MID_DEPTH      = 2;
    localparam int OUT_DEPTH      = 2;

    // Advance enable and incoming valid for a stalled-as-one pipeline.
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

>>> src/tbvf_queue.sv
// Small first-in first-out queue built from flip-flops.
// Used between the front and back parts and at the result side.
// Depends on nothing.
`default_nettype none

module tbvf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> src/tbvf_front.sv
// Front part: takes one state, forms the offsets to both primaries and
// flags a zero distance. Hands the classified item to the middle queue.
// Depends on nothing outside this file.
`default_nettype none

module tbvf_front #(
    parameter int W = 32,
    parameter int F = 28
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [W-1:0] pos_x,
    input  logic signed [W-1:0] pos_y,
    input  logic signed [W-1:0] vel_x,
    input  logic signed [W-1:0] vel_y,
    input  logic [F:0]          mu,
    output logic                q_push,
    input  logic                q_full,
    output logic [7*W+3:0]      q_data
);

    localparam logic [W:0] ONE_Q = {{(W-F){1'b0}}, 1'b1, {F{1'b0}}};

    logic                valid_reg, valid_next;
    logic signed [W-1:0] x_reg, y_reg, vx_reg, vy_reg;
    logic                accept;
    logic signed [W:0]   d1, d2;
    logic [W:0]          neg_d1, neg_d2;
    logic [W-1:0]        mag_d1, mag_d2, mag_y;
    logic                d1_neg, d2_neg, y_neg, zero;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        d1     = {x_reg[W-1], x_reg} - signed'({{(W-F){1'b0}}, mu});
        d2     = d1 + signed'(ONE_Q);
        neg_d1 = -d1;
        neg_d2 = -d2;
        d1_neg = d1[W];
        d2_neg = d2[W];
        y_neg  = y_reg[W-1];
        mag_d1 = d1_neg ? neg_d1[W-1:0] : d1[W-1:0];
        mag_d2 = d2_neg ? neg_d2[W-1:0] : d2[W-1:0];
        mag_y  = y_neg ? (~y_reg + 1'b1) : y_reg;
        zero   = ((d1 == '0) || (d2 == '0)) && (y_reg == '0);
    end

    assign q_data = {x_reg, y_reg, vx_reg, vy_reg, mag_d1, mag_d2, mag_y,
                     d1_neg, d2_neg, y_neg, zero};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= pos_x;
            y_reg  <= pos_y;
            vx_reg <= vel_x;
            vy_reg <= vel_y;
        end
    end

endmodule

`default_nettype wire

>>> src/tbvf_isqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
// A side tag travels along with each item.
// Depends on tbvf_pkg for the pipeline control bundle.
`default_nettype none

module tbvf_isqrt #(
    parameter int W     = 32,
    parameter int LANES = 2,
    parameter int TAG_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbvf_pkg::pipe_ctl_t   ctl,
    input  logic [2*W-1:0]        rad [LANES],
    input  logic [TAG_W-1:0]      tag_in,
    output logic                  out_valid,
    output logic [W-1:0]          root [LANES],
    output logic [TAG_W-1:0]      tag_out
);

    import tbvf_pkg::*;

    logic [2*W-1:0]   rem_reg [W][LANES];
    logic [2*W-1:0]   res_reg [W][LANES];
    logic [2*W-1:0]   rem_nx  [W][LANES];
    logic [2*W-1:0]   res_nx  [W][LANES];
    logic [TAG_W-1:0] tag_reg [W];
    logic [W-1:0]     val_reg;

    // Stage j tests the root bit of weight 2^(W-1-j).
    always_comb
    begin
        logic [2*W-1:0] r_in;
        logic [2*W-1:0] s_in;
        logic [2*W-1:0] one;
        logic [2*W-1:0] trial;
        for (int j = 0; j < W; j++)
        begin
            one = (2*W)'(1) << (2*(W-1-j));
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    r_in = rad[l];
                    s_in = '0;
                end
                else
                begin
                    r_in = rem_reg[j-1][l];
                    s_in = res_reg[j-1][l];
                end
                trial = s_in + one;
                if (r_in >= trial)
                begin
                    rem_nx[j][l] = r_in - trial;
                    res_nx[j][l] = (s_in >> 1) + one;
                end
                else
                begin
                    rem_nx[j][l] = r_in;
                    res_nx[j][l] = s_in >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (ctl.en)
        begin
            val_reg <= {val_reg[W-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg    <= rem_nx;
            res_reg    <= res_nx;
            tag_reg[0] <= tag_in;
            for (int j = 1; j < W; j++)
            begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = res_reg[W-1][l][W-1:0];
        end
    end

    assign out_valid = val_reg[W-1];
    assign tag_out   = tag_reg[W-1];

endmodule

`default_nettype wire

>>> src/tbvf_div.sv
// Pipelined restoring divider with a capped quotient, several lanes.
// One overflow test stage, one quotient bit per stage, one capping stage.
// Depends on tbvf_pkg for the pipeline control bundle.
`default_nettype none

module tbvf_div #(
    parameter int NW    = 117,
    parameter int DW    = 96,
    parameter int QB    = 35,
    parameter int LANES = 4,
    parameter int TAG_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tbvf_pkg::pipe_ctl_t ctl,
    input  logic [NW-1:0]       num [LANES],
    input  logic [DW-1:0]       den [LANES],
    input  logic [TAG_W-1:0]    tag_in,
    output logic                out_valid,
    output logic [QB-1:0]       mag [LANES],
    output logic [TAG_W-1:0]    tag_out
);

    import tbvf_pkg::*;

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;
    localparam logic [QB-1:0] CAP = QB'(1) << (QB-1);

    logic [NW-1:0]    rem_reg [QB+1][LANES];
    logic [NW-1:0]    rem_nx  [QB+1][LANES];
    logic [QB-1:0]    q_reg   [QB+1][LANES];
    logic [QB-1:0]    q_nx    [QB+1][LANES];
    logic [DW-1:0]    den_reg [QB+1][LANES];
    logic [DW-1:0]    den_nx  [QB+1][LANES];
    logic             ovf_reg [QB+1][LANES];
    logic             ovf_nx  [QB+1][LANES];
    logic [QB-1:0]    mag_reg [LANES];
    logic [QB-1:0]    mag_nx  [LANES];
    logic [TAG_W-1:0] tag_reg [QB+1];
    logic [TAG_W-1:0] tag_out_reg;
    logic [QB+1:0]    val_reg;

    // When the quotient cannot reach 2^QB, stage s settles bit QB-s.
    always_comb
    begin
        logic [CW-1:0] shifted;
        for (int l = 0; l < LANES; l++)
        begin
            rem_nx[0][l] = num[l];
            q_nx[0][l]   = '0;
            den_nx[0][l] = den[l];
            ovf_nx[0][l] = CW'(num[l]) >= (CW'(den[l]) << QB);
        end
        for (int s = 1; s <= QB; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shifted      = CW'(den_reg[s-1][l]) << (QB-s);
                den_nx[s][l] = den_reg[s-1][l];
                ovf_nx[s][l] = ovf_reg[s-1][l];
                if (CW'(rem_reg[s-1][l]) >= shifted)
                begin
                    rem_nx[s][l] = NW'(CW'(rem_reg[s-1][l]) - shifted);
                    q_nx[s][l]   = q_reg[s-1][l] | (QB'(1) << (QB-s));
                end
                else
                begin
                    rem_nx[s][l] = rem_reg[s-1][l];
                    q_nx[s][l]   = q_reg[s-1][l];
                end
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            mag_nx[l] = (ovf_reg[QB][l] || (q_reg[QB][l] > CAP)) ? CAP : q_reg[QB][l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (ctl.en)
        begin
            val_reg <= {val_reg[QB:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg     <= rem_nx;
            q_reg       <= q_nx;
            den_reg     <= den_nx;
            ovf_reg     <= ovf_nx;
            mag_reg     <= mag_nx;
            tag_reg[0]  <= tag_in;
            for (int s = 1; s <= QB; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            tag_out_reg <= tag_reg[QB];
        end
    end

    assign out_valid = val_reg[QB+1];
    assign mag       = mag_reg;
    assign tag_out   = tag_out_reg;

endmodule

`default_nettype wire

>>> src/tbvf_back.sv
// Back part: squares, square roots, cubed distances, the four gravity
// divisions and the final sums with clipping. Stalls as one pipeline.
// Depends on tbvf_pkg, tbvf_isqrt and tbvf_div.
`default_nettype none

module tbvf_back #(
    parameter int W = 32,
    parameter int F = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_pop,
    input  logic [7*W+3:0]   in_data,
    input  logic [F:0]       mu,
    input  logic             out_full,
    output logic             out_push,
    output logic [4*W:0]     out_data
);

    import tbvf_pkg::*;

    localparam int QW    = 7*W + 4;
    localparam int PW    = F + 1 + W;
    localparam int NW    = PW + 2*F;
    localparam int DW    = 3*W;
    localparam int QB    = W + 3;
    localparam int SUMW  = W + 6;
    localparam int PASSW = 4*PW + 4*W + 4;
    localparam int TAG1  = 4*W + PASSW;
    localparam int TAG2  = 4*W + 4;
    localparam logic [F:0] ONE_MU = {1'b1, {F{1'b0}}};
    localparam logic signed [SUMW-1:0] OUT_MAX = SUMW'((W+1)'(1) << (W-1)) - 1'b1;
    localparam logic signed [SUMW-1:0] OUT_MIN = -OUT_MAX - 1'b1;

    logic en;

    // Stage 0: squares and weight products.
    logic             v0_reg;
    logic [2*W-1:0]   sq_d1_reg, sq_d2_reg, sq_y_reg;
    logic [PASSW-1:0] pass0_reg, pass0_next;
    logic [W-1:0]     in_md1, in_md2, in_my;
    logic [F:0]       om;
    logic [PW-1:0]    p0, p1, p2, p3;

    // Stage 1: squared distances.
    logic             v1_reg;
    logic [2*W-1:0]   s1_reg, s2_reg;
    logic [PASSW-1:0] pass1_reg;

    // Square root.
    pipe_ctl_t        ctl;
    logic [2*W-1:0]   rad [2];
    logic [W-1:0]     root [2];
    logic             sq_valid;
    logic [TAG1-1:0]  tag1_out;
    logic [2*W-1:0]   s1_r, s2_r;

    // Stages 2 and 3: s times r split in halves, then recombined.
    logic             v2_reg, v3_reg;
    logic [2*W-1:0]   pp_lo1_reg, pp_hi1_reg, pp_lo2_reg, pp_hi2_reg;
    logic [PASSW-1:0] pass2_reg, pass3_reg;
    logic [DW-1:0]    den1_reg, den2_reg;

    // Division and final sums.
    logic [NW-1:0]    num [4];
    logic [DW-1:0]    den [4];
    logic [QB-1:0]    mag [4];
    logic             dv_valid;
    logic [TAG2-1:0]  tag2_out;
    logic signed [W-1:0]    fx, fy, fvx, fvy;
    logic                   f_d1n, f_d2n, f_yn, f_zero;
    logic signed [SUMW-1:0] t0, t1, t2, t3, ax, ay;
    logic signed [SUMW-1:0] ax_c, ay_c;
    logic                   sat;

    assign en     = !out_full;
    assign in_pop = en && in_valid;

    assign in_md1 = in_data[QW-1-4*W -: W];
    assign in_md2 = in_data[QW-1-5*W -: W];
    assign in_my  = in_data[QW-1-6*W -: W];
    assign om     = ONE_MU - mu;
    assign p0     = om * in_md1;
    assign p1     = om * in_my;
    assign p2     = mu * in_md2;
    assign p3     = mu * in_my;
    assign pass0_next = {p0, p1, p2, p3, in_data[QW-1 -: 4*W], in_data[3:0]};

    assign ctl    = '{en: en, valid: v1_reg};
    assign rad[0] = s1_reg;
    assign rad[1] = s2_reg;

    tbvf_isqrt #(
        .W     (W),
        .LANES (2),
        .TAG_W (TAG1)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rad       (rad),
        .tag_in    ({s1_reg, s2_reg, pass1_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .tag_out   (tag1_out)
    );

    assign s1_r = tag1_out[TAG1-1 -: 2*W];
    assign s2_r = tag1_out[TAG1-1-2*W -: 2*W];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            num[k] = {pass3_reg[PASSW-1-k*PW -: PW], {(2*F){1'b0}}};
        end
        den[0] = den1_reg;
        den[1] = den1_reg;
        den[2] = den2_reg;
        den[3] = den2_reg;
    end

    tbvf_div #(
        .NW    (NW),
        .DW    (DW),
        .QB    (QB),
        .LANES (4),
        .TAG_W (TAG2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       ('{en: en, valid: v3_reg}),
        .num       (num),
        .den       (den),
        .tag_in    (pass3_reg[TAG2-1:0]),
        .out_valid (dv_valid),
        .mag       (mag),
        .tag_out   (tag2_out)
    );

    // Gravity terms take the sign of their component; both sums are exact.
    always_comb
    begin
        fx     = signed'(tag2_out[TAG2-1 -: W]);
        fy     = signed'(tag2_out[TAG2-1-W -: W]);
        fvx    = signed'(tag2_out[TAG2-1-2*W -: W]);
        fvy    = signed'(tag2_out[TAG2-1-3*W -: W]);
        f_d1n  = tag2_out[3];
        f_d2n  = tag2_out[2];
        f_yn   = tag2_out[1];
        f_zero = tag2_out[0];
        t0 = signed'(SUMW'(mag[0]));
        t1 = signed'(SUMW'(mag[1]));
        t2 = signed'(SUMW'(mag[2]));
        t3 = signed'(SUMW'(mag[3]));
        if (f_d1n)
        begin
            t0 = -t0;
        end
        if (f_yn)
        begin
            t1 = -t1;
            t3 = -t3;
        end
        if (f_d2n)
        begin
            t2 = -t2;
        end
        ax = (SUMW'(fvy) <<< 1) + SUMW'(fx) - t0 - t2;
        ay = SUMW'(fy) - (SUMW'(fvx) <<< 1) - t1 - t3;
        sat  = 1'b0;
        ax_c = ax;
        ay_c = ay;
        if (f_zero)
        begin
            ax_c = OUT_MAX;
            ay_c = OUT_MAX;
            sat  = 1'b1;
        end
        else
        begin
            if (ax > OUT_MAX)
            begin
                ax_c = OUT_MAX;
                sat  = 1'b1;
            end
            else if (ax < OUT_MIN)
            begin
                ax_c = OUT_MIN;
                sat  = 1'b1;
            end
            if (ay > OUT_MAX)
            begin
                ay_c = OUT_MAX;
                sat  = 1'b1;
            end
            else if (ay < OUT_MIN)
            begin
                ay_c = OUT_MIN;
                sat  = 1'b1;
            end
        end
    end

    assign out_push = en && dv_valid;
    assign out_data = {fvx, fvy, ax_c[W-1:0], ay_c[W-1:0], sat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= sq_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_d1_reg  <= in_md1 * in_md1;
            sq_d2_reg  <= in_md2 * in_md2;
            sq_y_reg   <= in_my * in_my;
            pass0_reg  <= pass0_next;
            s1_reg     <= sq_d1_reg + sq_y_reg;
            s2_reg     <= sq_d2_reg + sq_y_reg;
            pass1_reg  <= pass0_reg;
            pp_lo1_reg <= s1_r[W-1:0] * root[0];
            pp_hi1_reg <= s1_r[2*W-1:W] * root[0];
            pp_lo2_reg <= s2_r[W-1:0] * root[1];
            pp_hi2_reg <= s2_r[2*W-1:W] * root[1];
            pass2_reg  <= tag1_out[PASSW-1:0];
            den1_reg   <= {pp_hi1_reg, {W{1'b0}}} + {{W{1'b0}}, pp_lo1_reg};
            den2_reg   <= {pp_hi2_reg, {W{1'b0}}} + {{W{1'b0}}, pp_lo2_reg};
            pass3_reg  <= pass2_reg;
        end
    end

endmodule

`default_nettype wire

>>> src/three_body_vector_field_unit.sv
// Top level of the three-body vector field unit.
// Depends on tbvf_pkg, tbvf_front, tbvf_queue and tbvf_back.
//
// Usage
//   The unit evaluates the planar circular restricted three-body equations
//   in the rotating frame. An input transfer (push high, full low) carries
//   one state pos_x, pos_y, vel_x, vel_y in signed fixed point with
//   FRAC_BITS fraction bits. Each state yields exactly one result transfer:
//   while empty is low the oldest result is on pos_rate_x, pos_rate_y,
//   vel_rate_x, vel_rate_y and saturated, and pop high takes it.
//   The mass ratio is written over the configuration channel (cfg_valid,
//   cfg_ready, mass_ratio) while no item is in flight; cfg_ready is always
//   high, and the value is rounded to FRAC_BITS fraction bits on the write.
//   The delay from input transfer to a result showing on the ports is set
//   by the one bit per stage square root and divider pipelines.
//   Throughput is one state per cycle while pop is held high. When pop is
//   held low, the result queue fills, the back pipeline freezes as a
//   whole, the middle queue fills and full rises; nothing is dropped and
//   the flow resumes at full rate once pop returns.
//   Reset empties all queues and pipelines and sets the mass ratio to zero.
`default_nettype none

module three_body_vector_field_unit #(
    parameter int WORD_WIDTH = tbvf_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS  = tbvf_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [WORD_WIDTH-1:0]    pos_x,
    input  logic signed [WORD_WIDTH-1:0]    pos_y,
    input  logic signed [WORD_WIDTH-1:0]    vel_x,
    input  logic signed [WORD_WIDTH-1:0]    vel_y,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [WORD_WIDTH-1:0]    pos_rate_x,
    output logic signed [WORD_WIDTH-1:0]    pos_rate_y,
    output logic signed [WORD_WIDTH-1:0]    vel_rate_x,
    output logic signed [WORD_WIDTH-1:0]    vel_rate_y,
    output logic                            saturated,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tbvf_pkg::CFG_WIDTH-1:0]  mass_ratio
);

    import tbvf_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = 7*W + 4;
    localparam int OW = 4*W + 1;
    localparam logic [CFG_WIDTH+F:0] MU_HALF = (CFG_WIDTH+F+1)'(1) << (CFG_WIDTH-1);

    logic [F:0]            mu_reg, mu_next;
    logic [CFG_WIDTH+F:0]  mu_wide;
    logic                  mq_push, mq_full, mq_empty, mq_pop;
    logic [QW-1:0]         mq_wr_data, mq_rd_data;
    logic                  oq_push, oq_full;
    logic [OW-1:0]         oq_wr_data, oq_rd_data;

    // Mass ratio is Q0.32; round half up to F fraction bits. It may reach 1.0.
    assign cfg_ready = 1'b1;
    assign mu_wide   = {1'b0, mass_ratio, {F{1'b0}}} + MU_HALF;
    assign mu_next   = mu_wide[CFG_WIDTH+F:CFG_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mu_reg <= mu_next;
        end
    end

    tbvf_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .vel_x  (vel_x),
        .vel_y  (vel_y),
        .mu     (mu_reg),
        .q_push (mq_push),
        .q_full (mq_full),
        .q_data (mq_wr_data)
    );

    tbvf_queue #(
        .DATA_W (QW),
        .DEPTH  (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mq_push),
        .wr_data (mq_wr_data),
        .rd_en   (mq_pop),
        .rd_data (mq_rd_data),
        .full    (mq_full),
        .empty   (mq_empty)
    );

    tbvf_back #(
        .W (W),
        .F (F)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mq_empty),
        .in_pop   (mq_pop),
        .in_data  (mq_rd_data),
        .mu       (mu_reg),
        .out_full (oq_full),
        .out_push (oq_push),
        .out_data (oq_wr_data)
    );

    // Result queue: it is the output register and lets the back keep going
    // for one more transfer while the receiver stalls.
    tbvf_queue #(
        .DATA_W (OW),
        .DEPTH  (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_wr_data),
        .rd_en   (pop && !empty),
        .rd_data (oq_rd_data),
        .full    (oq_full),
        .empty   (empty)
    );

    assign pos_rate_x = signed'(oq_rd_data[OW-1 -: W]);
    assign pos_rate_y = signed'(oq_rd_data[OW-1-W -: W]);
    assign vel_rate_x = signed'(oq_rd_data[OW-1-2*W -: W]);
    assign vel_rate_y = signed'(oq_rd_data[OW-1-3*W -: W]);
    assign saturated  = oq_rd_data[0];

`ifndef SYNTHESIS
    // The back must freeze before it could overrun the result queue.
    a_out_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result queue written while full");

    // The front must hold its item while the middle queue is full.
    a_mid_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        mq_push |-> !mq_full)
        else $error("middle queue written while full");

    // Right after reset no result can be waiting.
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("result shown right after reset");
`endif

endmodule

`default_nettype wire

>>> sim/tb_three_body_vector_field_unit.sv
// Self-checking testbench for three_body_vector_field_unit.
// Depends on tbvf_pkg and the unit's RTL; predicts every derivative with an
// exact integer model of the rotating-frame equations and checks each result.
`timescale 1ns / 1ps

module tb_three_body_vector_field_unit;
    import tbvf_pkg::*;

    localparam int WW = DEF_WORD_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam longint ONE_Q = longint'(1) << FB;
    localparam longint OUT_MAX = (longint'(1) << (WW - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (WW - 1));
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 2 * WW + 40;

    typedef struct {
        logic signed [WW-1:0] px;
        logic signed [WW-1:0] py;
        logic signed [WW-1:0] vx;
        logic signed [WW-1:0] vy;
    } state_t;

    typedef struct {
        logic signed [WW-1:0] prx;
        logic signed [WW-1:0] pry;
        logic signed [WW-1:0] vrx;
        logic signed [WW-1:0] vry;
        logic                 sat;
    } deriv_t;

    // Scoreboard: keeps its own copy of the mass ratio, predicts the derivative
    // of every accepted state and compares results in arrival order.
    class deriv_scoreboard;
        deriv_t pending_derivs[$];
        logic [CFG_WIDTH-1:0] mu_reg;
        int errors;

        function new();
            pending_derivs = {};
            mu_reg = '0;
            errors = 0;
        endfunction

        function void set_mass_ratio(logic [CFG_WIDTH-1:0] v);
            mu_reg = v;
        endfunction

        // mu rounded half up to FB fraction bits, in Q(FB).
        function longint mu_q();
            logic [CFG_WIDTH:0] t;
            t = {1'b0, mu_reg} + (33'd1 << (31 - FB));
            return longint'(t >> (32 - FB));
        endfunction

        function longint unsigned abs64(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Weight times component over r cubed, truncated in magnitude, capped.
        function longint gravity(longint unsigned w, longint c,
                                 longint unsigned s, longint unsigned r);
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] q;
            longint m;
            num = (128'(w) * 128'(abs64(c))) << (2 * FB);
            den = 128'(s) * 128'(r);
            q = num / den;
            m = (q > (128'd1 << (WW + 2))) ? (longint'(1) << (WW + 2)) : longint'(q);
            return c < 0 ? -m : m;
        endfunction

        function longint clip(longint v, inout logic flag);
            if (v > OUT_MAX)
            begin
                flag = 1'b1;
                return OUT_MAX;
            end
            if (v < OUT_MIN)
            begin
                flag = 1'b1;
                return OUT_MIN;
            end
            return v;
        endfunction

        function void note_state(state_t st);
            longint x, y, vx, vy, mu, d1, d2, ax, ay;
            longint unsigned om, s1, s2, r1, r2;
            deriv_t e;
            logic flag;
            x = st.px;
            y = st.py;
            vx = st.vx;
            vy = st.vy;
            mu = mu_q();
            om = ONE_Q - mu;
            d1 = x - mu;
            d2 = d1 + ONE_Q;
            s1 = abs64(d1) * abs64(d1) + abs64(y) * abs64(y);
            s2 = abs64(d2) * abs64(d2) + abs64(y) * abs64(y);
            flag = 1'b0;
            if (s1 == 0 || s2 == 0)
            begin
                // A state sitting on either primary pins both accelerations.
                ax = OUT_MAX;
                ay = OUT_MAX;
                flag = 1'b1;
            end
            else
            begin
                r1 = int_sqrt(s1);
                r2 = int_sqrt(s2);
                ax = 2 * vy + x - gravity(om, d1, s1, r1) - gravity(mu, d2, s2, r2);
                ay = -2 * vx + y - gravity(om, y, s1, r1) - gravity(mu, y, s2, r2);
                ax = clip(ax, flag);
                ay = clip(ay, flag);
            end
            e.prx = st.vx;
            e.pry = st.vy;
            e.vrx = ax[WW-1:0];
            e.vry = ay[WW-1:0];
            e.sat = flag;
            pending_derivs.push_back(e);
        endfunction

        task report(string what, logic [WW-1:0] got, logic [WW-1:0] want);
            $display("mismatch %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_deriv(deriv_t got);
            deriv_t e;
            if (pending_derivs.size() == 0)
            begin
                report("unexpected result", got.vrx, '0);
                return;
            end
            e = pending_derivs.pop_front();
            if (got.prx !== e.prx) report("pos_rate_x", got.prx, e.prx);
            if (got.pry !== e.pry) report("pos_rate_y", got.pry, e.pry);
            if (got.vrx !== e.vrx) report("vel_rate_x", got.vrx, e.vrx);
            if (got.vry !== e.vry) report("vel_rate_y", got.vry, e.vry);
            if (got.sat !== e.sat) report("saturated", WW'(got.sat), WW'(e.sat));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [WW-1:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [WW-1:0] pos_rate_x, pos_rate_y, vel_rate_x, vel_rate_y;
    logic saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_WIDTH-1:0] mass_ratio = '0;

    deriv_scoreboard sb = new();
    int states_sent = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;        // no idling on either side in the closing stretch
    bit long_hold_done = 1'b0;

    always #2 clk = ~clk;

    three_body_vector_field_unit dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .empty(empty), .pop(pop),
        .pos_rate_x(pos_rate_x), .pos_rate_y(pos_rate_y),
        .vel_rate_x(vel_rate_x), .vel_rate_y(vel_rate_y),
        .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .mass_ratio(mass_ratio)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Every result transfer is compared against the oldest prediction.
    always @(posedge clk)
    begin
        deriv_t got;
        if (rst_n && pop && !empty)
        begin
            got.prx = pos_rate_x;
            got.pry = pos_rate_y;
            got.vrx = vel_rate_x;
            got.vry = vel_rate_y;
            got.sat = saturated;
            sb.check_deriv(got);
        end
    end

    // Result side. It idles in random bursts, and once, just after the second
    // random phase has begun on an empty unit, it holds pop low long enough
    // that the unit backs up and raises full while the sender keeps offering
    // the rest of that phase, which is more than the unit can hold.
    initial
    begin
        int gap;
        gap = 0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && states_sent >= 96)
            begin
                long_hold_done = 1'b1;
                pop = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (quiet)
            begin
                pop = 1'b1;
            end
            else if (gap > 0)
            begin
                pop = 1'b0;
                gap--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                pop = 1'b0;
                gap = $urandom_range(0, 8);
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    // Offers one state and waits for its input transfer. Entered and left just
    // after a falling edge; push stays high so back-to-back states stream.
    task send_state(state_t st);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        push = 1'b1;
        pos_x = st.px;
        pos_y = st.py;
        vel_x = st.vx;
        vel_y = st.vy;
        do @(posedge clk); while (full);
        sb.note_state(st);
        states_sent++;
        @(negedge clk);
    endtask

    // Sender stops until every predicted result has arrived and the pipeline
    // has had time to empty; only then may the mass ratio change.
    task drain_unit();
        push = 1'b0;
        while (sb.pending_derivs.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_mass_ratio(logic [CFG_WIDTH-1:0] v);
        cfg_valid = 1'b1;
        mass_ratio = v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_mass_ratio(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function state_t mk(longint x, longint y, longint vx, longint vy);
        state_t st;
        st.px = x[WW-1:0];
        st.py = y[WW-1:0];
        st.vx = vx[WW-1:0];
        st.vy = vy[WW-1:0];
        return st;
    endfunction

    // Mostly states within a few units of the primaries, where the physics
    // lives; some full-range noise and some states placed on a primary.
    function state_t random_state();
        state_t st;
        longint mu;
        int pick;
        mu = sb.mu_q();
        pick = $urandom_range(0, 99);
        st.px = $urandom;
        st.py = $urandom;
        st.vx = $urandom;
        st.vy = $urandom;
        if (pick < 70)
        begin
            st.px = WW'(longint'($urandom_range(0, 32'h6000_0000)) - 32'h3000_0000);
            st.py = WW'(longint'($urandom_range(0, 32'h6000_0000)) - 32'h3000_0000);
            st.vx = WW'(longint'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
            st.vy = WW'(longint'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
        end
        else if (pick < 78)
        begin
            // Close approach to one primary, where the terms grow and clip.
            st.px = WW'(mu - ($urandom_range(0, 1) ? ONE_Q : 0)
                        + longint'($urandom_range(0, 64)) - 32);
            st.py = WW'(longint'($urandom_range(0, 64)) - 32);
        end
        else if (pick < 82)
        begin
            st.px = WW'(mu - ($urandom_range(0, 1) ? ONE_Q : 0));
            st.py = '0;
        end
        return st;
    endfunction

    initial
    begin
        logic [CFG_WIDTH-1:0] mu_list[5];
        mu_list = '{32'h0000_0000, 32'h0C4B_0F7E, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0};
        mu_list[4] = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value of mu is zero: the large primary sits at the origin.
        send_state(mk(0, 0, 0, 0));
        send_state(mk(-ONE_Q, 0, 1, -1));
        send_state(mk(ONE_Q, 0, ONE_Q, ONE_Q));
        drain_unit();

        // Equal masses, then directed states at the extremes and on both primaries.
        write_mass_ratio(32'h8000_0000);
        send_state(mk(ONE_Q / 2, 0, 0, 0));
        send_state(mk(-ONE_Q / 2, 0, 0, 0));
        send_state(mk(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX));
        send_state(mk(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN));
        send_state(mk(OUT_MAX, OUT_MIN, OUT_MIN, OUT_MAX));
        send_state(mk(OUT_MIN, OUT_MAX, OUT_MAX, OUT_MIN));
        send_state(mk(ONE_Q / 2 + 1, 0, 0, 0));
        send_state(mk(ONE_Q / 2, 1, 0, 0));
        send_state(mk(-ONE_Q / 2 - 1, -1, OUT_MAX, OUT_MIN));
        send_state(mk(0, ONE_Q, -ONE_Q, ONE_Q / 3));
        send_state(mk(-1, -1, -1, -1));
        send_state(mk(0, 0, OUT_MIN, OUT_MAX));
        drain_unit();

        // Random phases over several mass ratios, the largest register value
        // (mu rounds up to exactly one) and mu of zero among them.
        foreach (mu_list[i])
        begin
            write_mass_ratio(mu_list[i]);
            if (i == 4) quiet = 1'b1;
            repeat (80) send_state(random_state());
            drain_unit();
        end

        if (sb.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
src/tbvf_pkg.sv
src/tbvf_queue.sv
src/tbvf_front.sv
src/tbvf_isqrt.sv
src/tbvf_div.sv
src/tbvf_back.sv
src/three_body_vector_field_unit.sv
sim/tb_three_body_vector_field_unit.sv
